FILE: design/q2e_pkg.sv
// shared constants, types and helpers for the quaternion to euler converter
package q2e_pkg;

    localparam int unsigned TableLen = 24;
    localparam int unsigned AngW     = 33;

    localparam logic signed [AngW-1:0] HalfPiQ30 = 33'sd1686629713;

    typedef logic signed [AngW-1:0] t_angle;

    // arctangent of 2^-i in q.30 radians
    function automatic t_angle atan_q30(input logic [4:0] idx);
        t_angle r;
        r = '0;
        unique case (idx)
            5'd0:  r = 33'sd843314857;
            5'd1:  r = 33'sd497837829;
            5'd2:  r = 33'sd263043837;
            5'd3:  r = 33'sd133525159;
            5'd4:  r = 33'sd67021687;
            5'd5:  r = 33'sd33543516;
            5'd6:  r = 33'sd16775851;
            5'd7:  r = 33'sd8388437;
            5'd8:  r = 33'sd4194283;
            5'd9:  r = 33'sd2097149;
            5'd10: r = 33'sd1048576;
            5'd11: r = 33'sd524288;
            5'd12: r = 33'sd262144;
            5'd13: r = 33'sd131072;
            5'd14: r = 33'sd65536;
            5'd15: r = 33'sd32768;
            5'd16: r = 33'sd16384;
            5'd17: r = 33'sd8192;
            5'd18: r = 33'sd4096;
            5'd19: r = 33'sd2048;
            5'd20: r = 33'sd1024;
            5'd21: r = 33'sd512;
            5'd22: r = 33'sd256;
            5'd23: r = 33'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/q2e_cordic_cell.sv
// one vectoring cordic stage, registered, with its own valid bit
module q2e_cordic_cell #(
    parameter int STEP = 0,
    parameter int VW   = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [VW-1:0]  i_x,
    input  logic signed [VW-1:0]  i_y,
    input  q2e_pkg::t_angle       i_acc,
    output logic                  o_valid,
    output logic signed [VW-1:0]  o_x,
    output logic signed [VW-1:0]  o_y,
    output q2e_pkg::t_angle       o_acc
);
    import q2e_pkg::*;

    logic signed [VW-1:0] r_x, r_y, n_x, n_y;
    t_angle               r_acc, n_acc;
    logic                 r_valid;
    logic signed [VW-1:0] dx, dy;

    always_comb begin
        dx = i_y >>> STEP;
        dy = i_x >>> STEP;
        if (i_y > 0) begin
            n_x   = i_x + dx;
            n_y   = i_y - dy;
            n_acc = i_acc + atan_q30(5'(STEP));
        end else begin
            n_x   = i_x - dx;
            n_y   = i_y + dy;
            n_acc = i_acc - atan_q30(5'(STEP));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_acc <= n_acc;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_acc   = r_acc;
endmodule

FILE: design/q2e_isqrt_cell.sv
// one restoring square root step: one result bit per cell
module q2e_isqrt_cell #(
    parameter int STEP = 0,
    parameter int RW   = 32,
    parameter int F    = 14
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [RW-1:0]         i_rem,
    input  logic [RW-1:0]         i_res,
    input  logic signed [F+1:0]   i_sq,
    input  logic                  i_clamped,
    output logic [RW-1:0]         o_rem,
    output logic [RW-1:0]         o_res,
    output logic signed [F+1:0]   o_sq,
    output logic                  o_clamped
);
    import q2e_pkg::*;

    localparam logic [RW-1:0] Bit = RW'(1) << (RW - 2 - 2 * STEP);

    logic [RW-1:0] r_rem, r_res, n_rem, n_res;
    logic signed [F+1:0] r_sq;
    logic r_cl;

    always_comb begin
        if (i_rem >= i_res + Bit) begin
            n_rem = i_rem - (i_res + Bit);
            n_res = (i_res >> 1) + Bit;
        end else begin
            n_rem = i_rem;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_res <= n_res;
            r_sq  <= i_sq;
            r_cl  <= i_clamped;
        end
    end

    assign o_rem     = r_rem;
    assign o_res     = r_res;
    assign o_sq      = r_sq;
    assign o_clamped = r_cl;
endmodule

FILE: design/q2e_atan2_chain.sv
// atan2 as a row of cordic cells, with quadrant fold in front and rounding behind
module q2e_atan2_chain #(
    parameter int STEPS = 16,
    parameter int VW    = 20,
    parameter int OW    = 16,
    parameter int LIM   = 25736
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [VW-1:0] i_y,
    input  logic signed [VW-1:0] i_x,
    output logic                 o_valid,
    output logic signed [OW-1:0] o_angle
);
    import q2e_pkg::*;

    localparam int N = (STEPS < TableLen) ? STEPS : TableLen;

    logic                 v_vld [N+1];
    logic signed [VW-1:0] v_x   [N+1];
    logic signed [VW-1:0] v_y   [N+1];
    t_angle               v_acc [N+1];
    logic                 zz;

    always_comb begin
        zz = (i_x == '0) && (i_y == '0);
        v_vld[0] = i_valid;
        v_x[0]   = i_x;
        v_y[0]   = i_y;
        v_acc[0] = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                v_x[0] = i_y; v_y[0] = -i_x; v_acc[0] = HalfPiQ30;
            end else begin
                v_x[0] = -i_y; v_y[0] = i_x; v_acc[0] = -HalfPiQ30;
            end
        end
    end

    logic r_zz_line [N];

    for (genvar g = 0; g < N; g++) begin : g_cell
        q2e_cordic_cell #(.STEP(g), .VW(VW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en),
            .i_valid(v_vld[g]), .i_x(v_x[g]), .i_y(v_y[g]), .i_acc(v_acc[g]),
            .o_valid(v_vld[g+1]), .o_x(v_x[g+1]), .o_y(v_y[g+1]), .o_acc(v_acc[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (i_en) r_zz_line[g] <= (g == 0) ? zz : r_zz_line[(g == 0) ? 0 : g-1];
        end
    end

    t_angle rnd;
    always_comb begin
        rnd = (v_acc[N] + t_angle'(33'sd65536)) >>> 17;
        if (r_zz_line[N-1])      o_angle = '0;
        else if (rnd > LIM)      o_angle = OW'(LIM);
        else if (rnd < -LIM)     o_angle = OW'(-LIM);
        else                     o_angle = OW'(rnd);
    end
    assign o_valid = v_vld[N];
endmodule

FILE: design/quaternion_to_euler_core.sv
// top level: quaternion in, three euler angles out
// Converts one Q1.15 quaternion per clock into Q3.13 angles about y and z
// and a Q2.13 angle about x. Products and operand rounding take one
// register stage and the square of the asin operand one more; the asin
// path (angle about x) then passes a row of COMP_WIDTH square root cells,
// one result bit per cell, and all three angles pass a row of cordic
// cells, CORDIC_STEPS of them but at most 24, and then the output register;
// one word is taken every cycle, and the whole chain stalls only when the
// output register is full and not being taken.
module quaternion_to_euler_core #(
    parameter int CORDIC_STEPS = 16,
    parameter int COMP_WIDTH   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // quat_x, quat_y, quat_z, quat_w
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // angle_about_x, angle_about_y, angle_about_z, pad
    output logic        m_axis_tuser   // arg_clamped
);
    import q2e_pkg::*;

    localparam int F   = COMP_WIDTH - 2;
    localparam int SH  = 30 - F;
    localparam int VW  = F + 6;
    localparam int RW  = 2 * F + 4;
    localparam int NQ  = (RW - 2) / 2 + 1;
    localparam int NC  = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

    logic en;
    logic r_ovld;
    assign en            = !r_ovld || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [15:0] qx, qy, qz, qw;
    assign qx = s_axis_tdata[15:0];
    assign qy = s_axis_tdata[31:16];
    assign qz = s_axis_tdata[47:32];
    assign qw = s_axis_tdata[63:48];

    // stage 0: products, clamp, round to q.F
    logic signed [34:0] s30, ny30, dy30, nz30, dz30;
    logic signed [F+1:0] n_sq;
    logic signed [VW-1:0] n_ny, n_dy, n_nz, n_dz;
    logic n_cl;

    function automatic logic signed [VW-1:0] rq(input logic signed [34:0] v);
        logic signed [34:0] t;
        t = (v + (35'sd1 <<< (SH - 1))) >>> SH;
        return VW'(t);
    endfunction

    always_comb begin
        s30  = 35'(2 * (35'(qw) * 35'(qx) + 35'(qy) * 35'(qz)));
        ny30 = 35'(2 * (35'(qw) * 35'(qy) - 35'(qz) * 35'(qx)));
        dy30 = 35'sd1073741824 - 35'(2 * (35'(qx) * 35'(qx) + 35'(qy) * 35'(qy)));
        nz30 = 35'(2 * (35'(qw) * 35'(qz) + 35'(qx) * 35'(qy)));
        dz30 = 35'sd1073741824 - 35'(2 * (35'(qy) * 35'(qy) + 35'(qz) * 35'(qz)));
        n_cl = 1'b0;
        if (s30 > 35'sd1073741824) begin
            s30 = 35'sd1073741824; n_cl = 1'b1;
        end else if (s30 < -35'sd1073741824) begin
            s30 = -35'sd1073741824; n_cl = 1'b1;
        end
        n_sq = (F+2)'(rq(s30));
        n_ny = rq(ny30);
        n_dy = rq(dy30);
        n_nz = rq(nz30);
        n_dz = rq(dz30);
    end

    logic r_v0;
    logic signed [F+1:0]  r_sq;
    logic signed [VW-1:0] r_ny, r_dy, r_nz, r_dz;
    logic r_cl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (en)  r_v0 <= s_axis_tvalid;
        if (en) begin
            r_sq <= n_sq; r_ny <= n_ny; r_dy <= n_dy;
            r_nz <= n_nz; r_dz <= n_dz; r_cl <= n_cl;
        end
    end

    // stage 1: square, radicand
    logic [RW-1:0] one2, s2, n_rad;
    always_comb begin
        one2  = RW'(1) << (2 * F);
        s2    = RW'(r_sq) * RW'(r_sq);
        n_rad = (s2 >= one2) ? '0 : one2 - s2;
    end
    logic [RW-1:0] r_rad;
    logic signed [F+1:0] r_sq1;
    logic r_cl1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad <= n_rad; r_sq1 <= r_sq; r_cl1 <= r_cl;
        end
    end

    // square root cell row
    logic [RW-1:0]       q_rem [NQ+1];
    logic [RW-1:0]       q_res [NQ+1];
    logic signed [F+1:0] q_sq  [NQ+1];
    logic                q_cl  [NQ+1];
    assign q_rem[0] = r_rad;
    assign q_res[0] = '0;
    assign q_sq[0]  = r_sq1;
    assign q_cl[0]  = r_cl1;
    for (genvar g = 0; g < NQ; g++) begin : g_sq
        q2e_isqrt_cell #(.STEP(g), .RW(RW), .F(F)) u_sq (
            .i_clk(i_clk), .i_en(en),
            .i_rem(q_rem[g]), .i_res(q_res[g]), .i_sq(q_sq[g]), .i_clamped(q_cl[g]),
            .o_rem(q_rem[g+1]), .o_res(q_res[g+1]), .o_sq(q_sq[g+1]),
            .o_clamped(q_cl[g+1])
        );
    end

    // y and z operands wait alongside the square root row
    localparam int DL = NQ + 1;
    logic signed [VW-1:0] d_ny [DL], d_dy [DL], d_nz [DL], d_dz [DL];
    logic                 d_v  [DL];
    for (genvar g = 0; g < DL; g++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) d_v[g] <= 1'b0;
            else if (en)  d_v[g] <= (g == 0) ? r_v0 : d_v[(g == 0) ? 0 : g-1];
            if (en) begin
                d_ny[g] <= (g == 0) ? r_ny : d_ny[(g == 0) ? 0 : g-1];
                d_dy[g] <= (g == 0) ? r_dy : d_dy[(g == 0) ? 0 : g-1];
                d_nz[g] <= (g == 0) ? r_nz : d_nz[(g == 0) ? 0 : g-1];
                d_dz[g] <= (g == 0) ? r_dz : d_dz[(g == 0) ? 0 : g-1];
            end
        end
    end

    logic cl_line [NC];
    for (genvar g = 0; g < NC; g++) begin : g_cl
        always_ff @(posedge i_clk) begin
            if (en) cl_line[g] <= (g == 0) ? q_cl[NQ] : cl_line[(g == 0) ? 0 : g-1];
        end
    end

    logic signed [VW-1:0] ax_y, ax_x;
    assign ax_y = VW'(q_sq[NQ]);
    assign ax_x = VW'(q_res[NQ]);

    logic vx, vy, vz;
    logic signed [14:0] ang_x;
    logic signed [15:0] ang_y, ang_z;

    q2e_atan2_chain #(.STEPS(CORDIC_STEPS), .VW(VW), .OW(15), .LIM(12868)) u_ax (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(d_v[DL-1]),
        .i_y(ax_y), .i_x(ax_x), .o_valid(vx), .o_angle(ang_x)
    );
    q2e_atan2_chain #(.STEPS(CORDIC_STEPS), .VW(VW), .OW(16), .LIM(25736)) u_ay (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(d_v[DL-1]),
        .i_y(d_ny[DL-1]), .i_x(d_dy[DL-1]), .o_valid(vy), .o_angle(ang_y)
    );
    q2e_atan2_chain #(.STEPS(CORDIC_STEPS), .VW(VW), .OW(16), .LIM(25736)) u_az (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(d_v[DL-1]),
        .i_y(d_nz[DL-1]), .i_x(d_dz[DL-1]), .o_valid(vz), .o_angle(ang_z)
    );

    logic [47:0] r_odata;
    logic        r_ouser;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (en)  r_ovld <= vx;
        if (en) begin
            r_odata <= {1'b0, ang_z, ang_y, ang_x};
            r_ouser <= cl_line[NC-1];
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n) (vx == vy) && (vy == vz))
        else $error("angle lanes out of step");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");
    a_xrange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) <= 15'sd12868 &&
                           $signed(m_axis_tdata[14:0]) >= -15'sd12868))
        else $error("x angle out of range");
endmodule
